/* hdl/script_token_lexer_assert.svh */
// Assertion macros for the script token lexer.
`ifndef SCRIPT_TOKEN_LEXER_ASSERT_SVH
`define SCRIPT_TOKEN_LEXER_ASSERT_SVH

// Check expr at every clock edge outside reset.
`define STL_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/stl_pkg.sv */
package stl_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 1024;
    localparam int POS_WIDTH_DEF     = 24;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [1:0] KIND_IDENT   = 2'd0;
    localparam logic [1:0] KIND_INT     = 2'd1;
    localparam logic [1:0] KIND_FLOAT   = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    typedef struct packed {
        logic push_a;
        logic push_b;
    } t_push;

endpackage

/* hdl/script_token_lexer.sv */
// Streaming tokenizer: one script byte per item, identifiers and numbers reported as kind,
// start offset and saturating length. Bytes are taken at one per cycle while the input is not
// stalled; each passes an input register, is classified against the open token, and its
// tokens enter a four-entry result queue before they appear at the output. A byte that
// ends a number, opens an identifier and carries the end-of-text flag yields two tokens, which
// enter the queue together, number first; input stalls only while the queue holds three or more.
module script_token_lexer #(
    parameter int MAX_TOKEN_LEN = stl_pkg::MAX_TOKEN_LEN_DEF,
    parameter int POS_WIDTH     = stl_pkg::POS_WIDTH_DEF,
    localparam int LEN_WIDTH    = $clog2(MAX_TOKEN_LEN + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_text,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_token_kind,
    output logic [POS_WIDTH-1:0] o_token_start,
    output logic [LEN_WIDTH-1:0] o_token_length,
    output logic                 o_last_of_run
);
    import stl_pkg::*;

    localparam int DATA_WIDTH = 2 + POS_WIDTH + LEN_WIDTH + 1;

    t_push                 push;
    logic                  room;
    logic [1:0]            kind_a;
    logic [POS_WIDTH-1:0]  start_a;
    logic [LEN_WIDTH-1:0]  length_a;
    logic                  last_a;
    logic [1:0]            kind_b;
    logic [POS_WIDTH-1:0]  start_b;
    logic [LEN_WIDTH-1:0]  length_b;
    logic [DATA_WIDTH-1:0] data_a;
    logic [DATA_WIDTH-1:0] data_b;
    logic [DATA_WIDTH-1:0] data_out;

    stl_core #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
        .POS_WIDTH    (POS_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_char_code  (i_char_code),
        .i_end_of_text(i_end_of_text),
        .i_room       (room),
        .o_push       (push),
        .o_kind_a     (kind_a),
        .o_start_a    (start_a),
        .o_length_a   (length_a),
        .o_last_a     (last_a),
        .o_kind_b     (kind_b),
        .o_start_b    (start_b),
        .o_length_b   (length_b)
    );

    assign data_a = {kind_a, start_a, length_a, last_a};
    assign data_b = {kind_b, start_b, length_b, 1'b1};

    stl_fifo #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data_a(data_a),
        .i_data_b(data_b),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (data_out)
    );

    assign {o_token_kind, o_token_start, o_token_length, o_last_of_run} = data_out;

endmodule

/* hdl/stl_core.sv */
module stl_core #(
    parameter int MAX_TOKEN_LEN = 1024,
    parameter int POS_WIDTH     = 24,
    localparam int LEN_WIDTH    = $clog2(MAX_TOKEN_LEN + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_text,
    input  logic                 i_room,
    output stl_pkg::t_push       o_push,
    output logic [1:0]           o_kind_a,
    output logic [POS_WIDTH-1:0] o_start_a,
    output logic [LEN_WIDTH-1:0] o_length_a,
    output logic                 o_last_a,
    output logic [1:0]           o_kind_b,
    output logic [POS_WIDTH-1:0] o_start_b,
    output logic [LEN_WIDTH-1:0] o_length_b
);
    import stl_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } t_mode;

    localparam logic [LEN_WIDTH-1:0] LEN_MAX  = LEN_WIDTH'(MAX_TOKEN_LEN);
    localparam logic [1:0]           DOTS_SAT = 2'd2;

    logic                 r_valid;
    logic [7:0]           r_char;
    logic                 r_eot;
    t_mode                r_mode;
    logic [1:0]           r_dots;
    logic [POS_WIDTH-1:0] r_start;
    logic [LEN_WIDTH-1:0] r_len;
    logic [POS_WIDTH-1:0] r_pos;

    logic                 fire;
    logic                 letter;
    logic                 digit;
    logic                 dot;
    logic                 emit_a;
    logic                 emit_b;
    logic                 taken;
    logic [LEN_WIDTH-1:0] grown;
    t_mode                n_mode;
    logic [1:0]           n_dots;
    logic [POS_WIDTH-1:0] n_start;
    logic [LEN_WIDTH-1:0] n_len;

    function automatic logic [1:0] kind_of(t_mode mode, logic [1:0] dots);
        logic [1:0] kind;
        if (mode == MODE_IDENT) begin
            kind = KIND_IDENT;
        end else if (dots == 2'd0) begin
            kind = KIND_INT;
        end else if (dots == 2'd1) begin
            kind = KIND_FLOAT;
        end else begin
            kind = KIND_UNKNOWN;
        end
        return kind;
    endfunction

    assign fire    = r_valid && i_room;
    assign o_stall = r_valid && !i_room;

    assign letter = (r_char >= CH_UPPER_A && r_char <= CH_UPPER_Z)
                 || (r_char >= CH_LOWER_A && r_char <= CH_LOWER_Z)
                 || (r_char == CH_UNDER);
    assign digit  = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign dot    = (r_char == CH_DOT);
    assign grown  = (r_len < LEN_MAX) ? r_len + 1'b1 : r_len;

    always_comb begin
        emit_a  = 1'b0;
        taken   = 1'b0;
        n_mode  = r_mode;
        n_dots  = r_dots;
        n_start = r_start;
        n_len   = r_len;
        unique case (r_mode)
            MODE_IDENT: begin
                if (letter || digit) begin
                    taken = 1'b1;
                    n_len = grown;
                end else begin
                    emit_a = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (digit || dot) begin
                    taken = 1'b1;
                    n_len = grown;
                    if (dot && r_dots != DOTS_SAT) begin
                        n_dots = r_dots + 2'd1;
                    end
                end else begin
                    emit_a = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (!taken) begin
            n_dots  = 2'd0;
            n_start = r_pos;
            n_len   = LEN_WIDTH'(1);
            if (letter) begin
                n_mode = MODE_IDENT;
            end else if (digit) begin
                n_mode = MODE_NUMBER;
            end else begin
                n_mode  = MODE_IDLE;
                n_start = r_start;
                n_len   = '0;
            end
        end
        emit_b = r_eot && (n_mode != MODE_IDLE);
    end

    // Token closed by this byte goes first, the one flushed at end of text second.
    assign o_push.push_a = fire && (emit_a || emit_b);
    assign o_push.push_b = fire && emit_a && emit_b;
    assign o_kind_a      = emit_a ? kind_of(r_mode, r_dots) : kind_of(n_mode, n_dots);
    assign o_start_a     = emit_a ? r_start : n_start;
    assign o_length_a    = emit_a ? r_len : n_len;
    assign o_last_a      = !(emit_a && emit_b);
    assign o_kind_b      = kind_of(n_mode, n_dots);
    assign o_start_b     = n_start;
    assign o_length_b    = n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_char  <= '0;
            r_eot   <= 1'b0;
            r_mode  <= MODE_IDLE;
            r_dots  <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_pos   <= '0;
        end else begin
            if (!r_valid || fire) begin
                r_valid <= i_valid;
                r_char  <= i_char_code;
                r_eot   <= i_end_of_text;
            end
            if (fire) begin
                if (r_eot) begin
                    r_mode  <= MODE_IDLE;
                    r_dots  <= '0;
                    r_start <= '0;
                    r_len   <= '0;
                    r_pos   <= '0;
                end else begin
                    r_mode  <= n_mode;
                    r_dots  <= n_dots;
                    r_start <= n_start;
                    r_len   <= n_len;
                    r_pos   <= r_pos + 1'b1;
                end
            end
        end
    end

endmodule

/* hdl/stl_fifo.sv */
module stl_fifo #(
    parameter int DATA_WIDTH = 38
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stl_pkg::t_push        i_push,
    input  logic [DATA_WIDTH-1:0] i_data_a,
    input  logic [DATA_WIDTH-1:0] i_data_b,
    output logic                  o_room,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DATA_WIDTH-1:0] o_data
);
    import stl_pkg::*;

    localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]  r_wr_ptr;
    logic [PTR_WIDTH-1:0]  r_rd_ptr;
    logic [CNT_WIDTH-1:0]  r_count;
    logic [CNT_WIDTH-1:0]  n_count;
    logic                  pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= CNT_WIDTH'(QUEUE_DEPTH - 2));
    assign pop     = o_valid && !i_stall;
    assign n_count = r_count + CNT_WIDTH'(i_push.push_a) + CNT_WIDTH'(i_push.push_b)
                   - CNT_WIDTH'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.push_a) begin
            r_mem[r_wr_ptr] <= i_data_a;
        end
        if (i_push.push_b) begin
            r_mem[r_wr_ptr + 1'b1] <= i_data_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_WIDTH'(i_push.push_a) + PTR_WIDTH'(i_push.push_b);
            r_rd_ptr <= r_rd_ptr + PTR_WIDTH'(pop);
            r_count  <= n_count;
        end
    end

endmodule

/* hdl/stl_checker.sv */
`include "script_token_lexer_assert.svh"

module stl_checker #(
    parameter int MAX_TOKEN_LEN = stl_pkg::MAX_TOKEN_LEN_DEF,
    parameter int POS_WIDTH     = stl_pkg::POS_WIDTH_DEF,
    localparam int LEN_WIDTH    = $clog2(MAX_TOKEN_LEN + 1)
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [1:0]           o_token_kind,
    input logic [POS_WIDTH-1:0] o_token_start,
    input logic [LEN_WIDTH-1:0] o_token_length,
    input logic                 o_last_of_run
);

    `STL_ASSERT(a_length_range,
        !o_out_valid || (o_token_length != '0 && o_token_length <= LEN_WIDTH'(MAX_TOKEN_LEN)),
        "token length out of range")

    `STL_ASSERT(a_no_stall_when_empty, o_out_valid || !o_in_stall,
        "input stalled with empty result queue")

    `STL_ASSERT_NEXT(a_out_valid_holds, o_out_valid && i_out_stall, o_out_valid,
        "result dropped while stalled")

    `STL_ASSERT_NEXT(a_out_payload_holds, o_out_valid && i_out_stall,
        $stable(o_token_kind) && $stable(o_token_start) && $stable(o_token_length)
            && $stable(o_last_of_run),
        "result changed while stalled")

endmodule

bind script_token_lexer stl_checker #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .POS_WIDTH    (POS_WIDTH)
) u_checker (.*);

/* verif/script_token_checker.sv */
module script_token_checker #(
    parameter int MAX_TOKEN_LEN = stl_pkg::MAX_TOKEN_LEN_DEF,
    parameter int POS_WIDTH     = stl_pkg::POS_WIDTH_DEF,
    localparam int LEN_WIDTH    = $clog2(MAX_TOKEN_LEN + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_text,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [1:0]           i_token_kind,
    input  logic [POS_WIDTH-1:0] i_token_start,
    input  logic [LEN_WIDTH-1:0] i_token_length,
    input  logic                 i_last_of_run,
    output int                   o_fail_count,
    output int                   o_tokens_pending
);
    import stl_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER
    } t_scan_mode;

    typedef struct packed {
        logic [1:0]           kind;
        logic [POS_WIDTH-1:0] start;
        logic [LEN_WIDTH-1:0] length;
        logic                 last;
    } t_token;

    t_scan_mode           scan_mode;
    logic [1:0]           dot_seen;
    logic [POS_WIDTH-1:0] tok_start;
    logic [LEN_WIDTH-1:0] tok_len;
    logic [POS_WIDTH-1:0] next_pos;

    t_token expected_tokens[$];
    t_token seen_token;
    t_token want_token;
    int     failures = 0;
    int     results_seen = 0;

    function automatic void restart_scan();
        scan_mode = SCAN_IDLE;
        dot_seen  = '0;
        tok_start = '0;
        tok_len   = '0;
        next_pos  = '0;
    endfunction

    function automatic t_token close_token();
        t_token tok;
        if (scan_mode == SCAN_IDENT) begin
            tok.kind = KIND_IDENT;
        end else if (dot_seen == 2'd0) begin
            tok.kind = KIND_INT;
        end else if (dot_seen == 2'd1) begin
            tok.kind = KIND_FLOAT;
        end else begin
            tok.kind = KIND_UNKNOWN;
        end
        tok.start  = tok_start;
        tok.length = tok_len;
        tok.last   = 1'b0;
        scan_mode  = SCAN_IDLE;
        dot_seen   = '0;
        tok_len    = '0;
        return tok;
    endfunction

    task automatic tokenize_byte(input logic [7:0] c, input logic eot);
        t_token made[2];
        int     n;
        logic   letter;
        logic   digit;
        logic   dot;
        logic   taken;
        letter = (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z)
                 || c == CH_UNDER;
        digit  = c >= CH_ZERO && c <= CH_NINE;
        dot    = c == CH_DOT;
        n      = 0;
        taken  = 1'b0;
        if (scan_mode == SCAN_IDENT) begin
            if (letter || digit) begin
                if (tok_len < MAX_TOKEN_LEN) tok_len++;
                taken = 1'b1;
            end else begin
                made[n] = close_token();
                n++;
            end
        end else if (scan_mode == SCAN_NUMBER) begin
            if (digit || dot) begin
                if (tok_len < MAX_TOKEN_LEN) tok_len++;
                if (dot && dot_seen < 2'd2) dot_seen++;
                taken = 1'b1;
            end else begin
                made[n] = close_token();
                n++;
            end
        end
        if (!taken && (letter || digit)) begin
            scan_mode = letter ? SCAN_IDENT : SCAN_NUMBER;
            dot_seen  = '0;
            tok_start = next_pos;
            tok_len   = LEN_WIDTH'(1);
        end
        if (eot) begin
            if (scan_mode != SCAN_IDLE) begin
                made[n] = close_token();
                n++;
            end
            restart_scan();
        end else begin
            next_pos++;
        end
        for (int i = 0; i < n; i++) begin
            made[i].last = (i == n - 1);
            expected_tokens.push_back(made[i]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_scan();
            expected_tokens.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                seen_token = {i_token_kind, i_token_start, i_token_length, i_last_of_run};
                if (expected_tokens.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("token %0d unexpected: kind %0d start %0d length %0d last %0d",
                                 results_seen, seen_token.kind, seen_token.start,
                                 seen_token.length, seen_token.last);
                end else begin
                    want_token = expected_tokens.pop_front();
                    if (seen_token !== want_token) begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display({"token %0d mismatch: expected kind %0d start %0d ",
                                      "length %0d last %0d, got kind %0d start %0d ",
                                      "length %0d last %0d"},
                                     results_seen, want_token.kind, want_token.start,
                                     want_token.length, want_token.last, seen_token.kind,
                                     seen_token.start, seen_token.length, seen_token.last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) tokenize_byte(i_char_code, i_end_of_text);
        end
        o_fail_count     <= failures;
        o_tokens_pending <= expected_tokens.size();
    end

endmodule

/* verif/tb_script_token_lexer.sv */
module tb_script_token_lexer;
    import stl_pkg::*;

    localparam int LEN_WIDTH    = $clog2(MAX_TOKEN_LEN_DEF + 1);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 150;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam string      PUNCT    = ",;()=+-*/@[]{}:!#\t\n";

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [7:0]               i_char_code;
    logic                     i_end_of_text;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [1:0]               o_token_kind;
    logic [POS_WIDTH_DEF-1:0] o_token_start;
    logic [LEN_WIDTH-1:0]     o_token_length;
    logic                     o_last_of_run;

    int fail_count;
    int tokens_pending;
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_asked   = 0;
    int holds_served = 0;
    int bytes_sent   = 0;
    int cycle_count  = 0;
    int phase_target;

    logic [7:0] script_q[$];

    script_token_lexer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    script_token_checker token_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_char_code      (i_char_code),
        .i_end_of_text    (i_end_of_text),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_token_kind     (o_token_kind),
        .i_token_start    (o_token_start),
        .i_token_length   (o_token_length),
        .i_last_of_run    (o_last_of_run),
        .o_fail_count     (fail_count),
        .o_tokens_pending (tokens_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** script_token_lexer: FAILED **");
        $finish;
    end

    // output side: random stall, or a long hold-off on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != holds_served) begin
                holds_served++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_item(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_char_code   <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic eot_last);
        for (int i = 0; i < s.len(); i++) send_item(s[i], eot_last && i == s.len() - 1);
    endtask

    task automatic send_script();
        for (int i = 0; i < script_q.size(); i++) send_item(script_q[i], i == script_q.size() - 1);
        script_q.delete();
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(2))
            0:       return CH_UPPER_A + 8'($urandom_range(25));
            1:       return CH_LOWER_A + 8'($urandom_range(25));
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] pick_gap_byte();
        case ($urandom_range(4))
            0:       return CH_SPACE;
            1:       return PUNCT[$urandom_range(PUNCT.len() - 1)];
            2:       return 8'h80 + 8'($urandom_range(127));
            3:       return CH_DOT;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_ident(input int len);
        script_q.push_back(pick_letter());
        for (int i = 1; i < len; i++)
            script_q.push_back($urandom_range(3) == 0 ? pick_digit() : pick_letter());
    endtask

    task automatic add_number(input int len);
        int dot_mode;
        int dot_at;
        dot_mode = $urandom_range(2);
        dot_at   = (len > 1) ? $urandom_range(1, len - 1) : 0;
        script_q.push_back(pick_digit());
        for (int i = 1; i < len; i++) begin
            if ((dot_mode == 1 && i == dot_at) || (dot_mode == 2 && $urandom_range(4) < 2))
                script_q.push_back(CH_DOT);
            else
                script_q.push_back(pick_digit());
        end
    endtask

    task automatic add_gap();
        repeat ($urandom_range(1, 3)) script_q.push_back(pick_gap_byte());
    endtask

    task automatic random_script();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) script_q.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(9) < 3) add_gap();
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(9) < 5) add_ident($urandom_range(1, 8));
                else add_number($urandom_range(1, 7));
                if ($urandom_range(3) != 0) add_gap();
            end
        end
        send_script();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_char_code   <= '0;
        i_end_of_text <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("a", 1'b1);
        send_text("_Az9 ", 1'b0);
        send_text("0.5.1x.", 1'b0);
        send_text("7 ", 1'b0);
        send_text("3.14", 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h00, 1'b0);
        send_text("8z", 1'b1);
        send_item(CH_SPACE, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct = (phase == 0) ? 27 : (phase == 1) ? 54 : 0;
            stall_pct    = (phase == 0) ? 54 : (phase == 1) ? 27 : 0;
            if (phase == 0) begin
                // saturate a long number, letter right after it
                add_number($urandom_range(1025, 1032));
                add_ident($urandom_range(1, 6));
                send_script();
            end
            if (phase == 2) begin
                hold_asked <= hold_asked + 1;
                repeat (20) begin
                    add_ident($urandom_range(1, 3));
                    script_q.push_back(CH_SPACE);
                end
                send_script();
            end
            phase_target = bytes_sent + RANDOM_ITEMS / 3;
            while (bytes_sent < phase_target) random_script();
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tokens_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && tokens_pending == 0) begin
            $display("** script_token_lexer: PASSED **");
        end else begin
            $display("** script_token_lexer: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/stl_pkg.sv
hdl/stl_core.sv
hdl/stl_fifo.sv
hdl/script_token_lexer.sv
hdl/stl_checker.sv
verif/script_token_checker.sv
verif/tb_script_token_lexer.sv
